/* hdl/bmg_pkg.sv */
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared types, constants and face table of the box mesh generator.
// ----------------------------------------------------------------------------
package bmg_pkg;

   // field widths
   localparam int SEG_W       = 7;
   localparam int DIM_W       = 16;
   localparam int COORD_W     = 16;
   localparam int TEX_W       = 17;
   localparam int INDEX_W     = 15;
   localparam int FACE_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int MAX_SEGMENTS = 64;

   // signed grid offset (2*i - g) and its product with an extent
   localparam int DIFF_W = SEG_W + 2;
   localparam int PROD_W = DIFF_W + DIM_W + 1;

   // shared divider: radix-16 restoring, four quotient bits per cycle
   localparam int DIVIDEND_W    = 28;
   localparam int DIVISOR_W     = SEG_W + 1;
   localparam int DIV_STEP_BITS = 4;
   localparam int DIV_CYCLES    = DIVIDEND_W / DIV_STEP_BITS;
   localparam int DIV_COUNT_W   = $clog2(DIV_CYCLES);

   localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(65536);

   // face codes, also the normal
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;
   localparam logic [FACE_W-1:0] FACE_LAST  = FACE_NEG_Z;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOX_WIDTH  = 3'd0,
      CSR_BOX_HEIGHT = 3'd1,
      CSR_BOX_DEPTH  = 3'd2,
      CSR_SEGMENTS_X = 3'd3,
      CSR_SEGMENTS_Y = 3'd4,
      CSR_SEGMENTS_Z = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      axis_type u_axis;
      axis_type v_axis;
      axis_type w_axis;
      logic     u_neg;
      logic     v_neg;
      logic     w_neg;
   } face_info_type;

   typedef enum logic [1:0] {
      DIV_POS_U = 2'd0,
      DIV_POS_V = 2'd1,
      DIV_TEX_U = 2'd2,
      DIV_TEX_V = 2'd3
   } div_op_type;

   typedef struct packed {
      logic       accept;
      logic       setup;
      logic       div_start;
      logic       div_capture;
      div_op_type div_op;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic tri_phase;
      logic div_done;
   } status_type;

   function automatic face_info_type face_lookup(input logic [FACE_W-1:0] face);
      face_info_type fi;
      unique case (face)
         FACE_POS_X: fi = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0};
         FACE_NEG_X: fi = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1, 1'b1};
         FACE_POS_Y: fi = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0, 1'b0};
         FACE_NEG_Y: fi = '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1, 1'b1};
         FACE_POS_Z: fi = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1, 1'b0};
         FACE_NEG_Z: fi = '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1, 1'b1};
         default:    fi = '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0};
      endcase
      return fi;
   endfunction

   // zero counts as one cell, large counts clamp
   function automatic logic [SEG_W-1:0] grid_limit(input logic [SEG_W-1:0] seg);
      logic [SEG_W-1:0] g;
      if (seg == '0)
         g = SEG_W'(1);
      else if (seg > SEG_W'(MAX_SEGMENTS))
         g = SEG_W'(MAX_SEGMENTS);
      else
         g = seg;
      return g;
   endfunction

endpackage

/* hdl/bmg_divider.sv */
// ----------------------------------------------------------------------------
// bmg_divider
// Iterative unsigned divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module bmg_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bmg_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [bmg_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                done,
   output logic [bmg_pkg::DIVIDEND_W-1:0]      quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [bmg_pkg::DIV_COUNT_W-1:0]     count_ff, count_in;
   logic [bmg_pkg::DIVIDEND_W-1:0]      quo_ff, quo_in;
   logic [bmg_pkg::DIVISOR_W-1:0]       rem_ff, rem_in;
   logic [bmg_pkg::DIVISOR_W-1:0]       den_ff, den_in;
   logic [bmg_pkg::DIVIDEND_W-1:0]      quo_work;
   logic [bmg_pkg::DIVISOR_W-1:0]       rem_work;
   logic [bmg_pkg::DIVISOR_W:0]         trial;
   logic                                last_step;

   // four restoring steps: shift in the next dividend bit, subtract if it fits
   always_comb begin
      quo_work = quo_ff;
      rem_work = rem_ff;
      trial    = '0;
      for (int k = 0; k < bmg_pkg::DIV_STEP_BITS; k++) begin
         trial    = {rem_work, quo_work[bmg_pkg::DIVIDEND_W-1]};
         quo_work = {quo_work[bmg_pkg::DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            trial       = trial - {1'b0, den_ff};
            quo_work[0] = 1'b1;
         end
         rem_work = trial[bmg_pkg::DIVISOR_W-1:0];
      end
   end

   assign last_step = busy_ff && (count_ff == bmg_pkg::DIV_COUNT_W'(bmg_pkg::DIV_CYCLES - 1));

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      done_in  = last_step;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = quo_work;
         rem_in   = rem_work;
         count_in = count_ff + bmg_pkg::DIV_COUNT_W'(1);
         if (last_step)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/bmg_datapath.sv */
// ----------------------------------------------------------------------------
// bmg_datapath
// Configuration registers, record counters, vertex and index arithmetic.
// ----------------------------------------------------------------------------
module bmg_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bmg_pkg::cmd_type                      cmd,
   output bmg_pkg::status_type                   status,
   input  logic                                  req_restart,
   input  logic                                  csr_write,
   input  logic [bmg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bmg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  rsp_record_kind,
   output logic [bmg_pkg::FACE_W-1:0]            rsp_face_id,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_x,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_y,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_z,
   output logic [bmg_pkg::TEX_W-1:0]             rsp_tex_u,
   output logic [bmg_pkg::TEX_W-1:0]             rsp_tex_v,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_a,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_b,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_c,
   output logic                                  rsp_last_record
);

   // configuration
   logic [bmg_pkg::DIM_W-1:0]   width_ff, height_ff, depth_ff;
   logic [bmg_pkg::SEG_W-1:0]   seg_x_ff, seg_y_ff, seg_z_ff;

   // record counters
   logic [bmg_pkg::FACE_W-1:0]  face_ff, face_in;
   logic                        phase_ff, phase_in;
   logic [bmg_pkg::SEG_W-1:0]   col_ff, col_in;
   logic [bmg_pkg::SEG_W-1:0]   row_ff, row_in;
   logic                        second_ff, second_in;
   logic [bmg_pkg::INDEX_W-1:0] base_ff, base_in;
   logic                        end_box;

   // arithmetic
   bmg_pkg::face_info_type              face_info;
   logic [bmg_pkg::DIM_W-1:0]           ext_u, ext_v, ext_w;
   logic [bmg_pkg::SEG_W-1:0]           gx, gy, pitch, rows;
   logic signed [bmg_pkg::DIFF_W-1:0]   diff_u, diff_v;
   logic signed [bmg_pkg::DIM_W:0]      ext_u_s, ext_v_s;
   logic signed [bmg_pkg::PROD_W-1:0]   prod_u, prod_v;
   logic signed [bmg_pkg::PROD_W-1:0]   prod_u_ff, prod_v_ff;
   logic [bmg_pkg::PROD_W-1:0]          mag_u, mag_v;
   logic [bmg_pkg::DIVIDEND_W-1:0]      div_dividend, div_quotient;
   logic [bmg_pkg::DIVISOR_W-1:0]       div_divisor;
   logic                                div_done;
   logic signed [bmg_pkg::COORD_W-1:0]  coord_u_ff, coord_v_ff, coord_w;
   logic [bmg_pkg::TEX_W-1:0]           tex_u_ff, tex_vf_ff;
   logic [bmg_pkg::DIM_W:0]             half_sum;
   logic [bmg_pkg::DIM_W-1:0]           half_w;
   logic [2*bmg_pkg::SEG_W-1:0]         pitch_row, face_verts;
   logic [bmg_pkg::INDEX_W-1:0]         idx_a, idx_b, idx_c, idx_d;
   logic [bmg_pkg::SEG_W:0]             col_inc, row_inc;

   // output registers
   logic                                kind_ff, last_ff;
   logic [bmg_pkg::FACE_W-1:0]          face_id_ff;
   logic signed [bmg_pkg::COORD_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [bmg_pkg::TEX_W-1:0]           tex_u_out_ff, tex_v_out_ff;
   logic [bmg_pkg::INDEX_W-1:0]         index_a_ff, index_b_ff, index_c_ff;

   function automatic logic [bmg_pkg::DIM_W-1:0] pick_dim(input bmg_pkg::axis_type a,
         input logic [bmg_pkg::DIM_W-1:0] x, input logic [bmg_pkg::DIM_W-1:0] y,
         input logic [bmg_pkg::DIM_W-1:0] z);
      logic [bmg_pkg::DIM_W-1:0] r;
      unique case (a)
         bmg_pkg::AXIS_X: r = x;
         bmg_pkg::AXIS_Y: r = y;
         default:         r = z;
      endcase
      return r;
   endfunction

   function automatic logic [bmg_pkg::SEG_W-1:0] pick_seg(input bmg_pkg::axis_type a,
         input logic [bmg_pkg::SEG_W-1:0] x, input logic [bmg_pkg::SEG_W-1:0] y,
         input logic [bmg_pkg::SEG_W-1:0] z);
      logic [bmg_pkg::SEG_W-1:0] r;
      unique case (a)
         bmg_pkg::AXIS_X: r = x;
         bmg_pkg::AXIS_Y: r = y;
         default:         r = z;
      endcase
      return r;
   endfunction

   // apply sign and clamp to the signed 16-bit range
   function automatic logic signed [bmg_pkg::COORD_W-1:0] sat_coord(
         input logic [bmg_pkg::DIVIDEND_W-1:0] q, input logic neg);
      logic signed [bmg_pkg::COORD_W-1:0] r;
      logic                               big;
      big = (q[bmg_pkg::DIVIDEND_W-1:bmg_pkg::COORD_W-1] != '0);
      if (!neg)
         r = big ? {1'b0, {(bmg_pkg::COORD_W-1){1'b1}}} : q[bmg_pkg::COORD_W-1:0];
      else
         r = big ? {1'b1, {(bmg_pkg::COORD_W-1){1'b0}}} : -q[bmg_pkg::COORD_W-1:0];
      return r;
   endfunction

   function automatic logic [bmg_pkg::TEX_W-1:0] tex_limit(
         input logic [bmg_pkg::DIVIDEND_W-1:0] q);
      logic [bmg_pkg::TEX_W-1:0] r;
      if (q > bmg_pkg::DIVIDEND_W'(bmg_pkg::TEX_ONE))
         r = bmg_pkg::TEX_ONE;
      else
         r = q[bmg_pkg::TEX_W-1:0];
      return r;
   endfunction

   function automatic logic signed [bmg_pkg::COORD_W-1:0] place(
         input bmg_pkg::axis_type target, input bmg_pkg::face_info_type fi,
         input logic signed [bmg_pkg::COORD_W-1:0] cu,
         input logic signed [bmg_pkg::COORD_W-1:0] cv,
         input logic signed [bmg_pkg::COORD_W-1:0] cw);
      logic signed [bmg_pkg::COORD_W-1:0] r;
      if (fi.u_axis == target)
         r = cu;
      else if (fi.v_axis == target)
         r = cv;
      else
         r = cw;
      return r;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bmg_pkg::DIM_W'(256);
         height_ff <= bmg_pkg::DIM_W'(256);
         depth_ff  <= bmg_pkg::DIM_W'(256);
         seg_x_ff  <= bmg_pkg::SEG_W'(1);
         seg_y_ff  <= bmg_pkg::SEG_W'(1);
         seg_z_ff  <= bmg_pkg::SEG_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            bmg_pkg::CSR_BOX_WIDTH:  width_ff  <= csr_wdata;
            bmg_pkg::CSR_BOX_HEIGHT: height_ff <= csr_wdata;
            bmg_pkg::CSR_BOX_DEPTH:  depth_ff  <= csr_wdata;
            bmg_pkg::CSR_SEGMENTS_X: seg_x_ff  <= csr_wdata[bmg_pkg::SEG_W-1:0];
            bmg_pkg::CSR_SEGMENTS_Y: seg_y_ff  <= csr_wdata[bmg_pkg::SEG_W-1:0];
            bmg_pkg::CSR_SEGMENTS_Z: seg_z_ff  <= csr_wdata[bmg_pkg::SEG_W-1:0];
            default: ;
         endcase
      end
   end

   // face geometry
   always_comb begin
      face_info = bmg_pkg::face_lookup(face_ff);
      ext_u     = pick_dim(face_info.u_axis, width_ff, height_ff, depth_ff);
      ext_v     = pick_dim(face_info.v_axis, width_ff, height_ff, depth_ff);
      ext_w     = pick_dim(face_info.w_axis, width_ff, height_ff, depth_ff);
      gx        = bmg_pkg::grid_limit(pick_seg(face_info.u_axis, seg_x_ff, seg_y_ff, seg_z_ff));
      gy        = bmg_pkg::grid_limit(pick_seg(face_info.v_axis, seg_x_ff, seg_y_ff, seg_z_ff));
      pitch     = gx + bmg_pkg::SEG_W'(1);
      rows      = gy + bmg_pkg::SEG_W'(1);
   end

   // numerators of the grid coordinates: extent * (2*index - grid)
   assign diff_u  = $signed({1'b0, col_ff, 1'b0}) - $signed({2'b00, gx});
   assign diff_v  = $signed({1'b0, row_ff, 1'b0}) - $signed({2'b00, gy});
   assign ext_u_s = $signed({1'b0, ext_u});
   assign ext_v_s = $signed({1'b0, ext_v});
   assign prod_u  = diff_u * ext_u_s;
   assign prod_v  = diff_v * ext_v_s;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         prod_u_ff <= prod_u;
         prod_v_ff <= prod_v;
      end
   end

   assign mag_u = prod_u_ff[bmg_pkg::PROD_W-1] ? -prod_u_ff : prod_u_ff;
   assign mag_v = prod_v_ff[bmg_pkg::PROD_W-1] ? -prod_v_ff : prod_v_ff;

   // round half away from zero: (|n| + g) / (2g); UV: (i*65536 + g/2) / g
   always_comb begin
      case (cmd.div_op)
         bmg_pkg::DIV_POS_U: begin
            div_dividend = bmg_pkg::DIVIDEND_W'(mag_u) + bmg_pkg::DIVIDEND_W'(gx);
            div_divisor  = {gx, 1'b0};
         end
         bmg_pkg::DIV_POS_V: begin
            div_dividend = bmg_pkg::DIVIDEND_W'(mag_v) + bmg_pkg::DIVIDEND_W'(gy);
            div_divisor  = {gy, 1'b0};
         end
         bmg_pkg::DIV_TEX_U: begin
            div_dividend = bmg_pkg::DIVIDEND_W'({col_ff, 16'h0000})
                         + bmg_pkg::DIVIDEND_W'(gx[bmg_pkg::SEG_W-1:1]);
            div_divisor  = {1'b0, gx};
         end
         default: begin
            div_dividend = bmg_pkg::DIVIDEND_W'({row_ff, 16'h0000})
                         + bmg_pkg::DIVIDEND_W'(gy[bmg_pkg::SEG_W-1:1]);
            div_divisor  = {1'b0, gy};
         end
      endcase
   end

   bmg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.div_capture) begin
         case (cmd.div_op)
            bmg_pkg::DIV_POS_U:
               coord_u_ff <= sat_coord(div_quotient,
                                       prod_u_ff[bmg_pkg::PROD_W-1] ^ face_info.u_neg);
            bmg_pkg::DIV_POS_V:
               coord_v_ff <= sat_coord(div_quotient,
                                       prod_v_ff[bmg_pkg::PROD_W-1] ^ face_info.v_neg);
            bmg_pkg::DIV_TEX_U: tex_u_ff  <= tex_limit(div_quotient);
            default:            tex_vf_ff <= tex_limit(div_quotient);
         endcase
      end
   end

   // plane offset: half the third extent, rounded away from zero
   always_comb begin
      half_sum = {1'b0, ext_w} + (bmg_pkg::DIM_W + 1)'(1);
      half_w   = half_sum[bmg_pkg::DIM_W:1];
      if (face_info.w_neg)
         coord_w = -half_w;
      else if (half_w[bmg_pkg::DIM_W-1])
         coord_w = {1'b0, {(bmg_pkg::COORD_W-1){1'b1}}};
      else
         coord_w = half_w;
   end

   // triangle corners of the current cell
   always_comb begin
      pitch_row  = pitch * row_ff;
      face_verts = pitch * rows;
      idx_a      = base_ff + bmg_pkg::INDEX_W'(col_ff) + bmg_pkg::INDEX_W'(pitch_row);
      idx_d      = idx_a + bmg_pkg::INDEX_W'(1);
      idx_b      = idx_a + bmg_pkg::INDEX_W'(pitch);
      idx_c      = idx_b + bmg_pkg::INDEX_W'(1);
   end

   // advance to the next record
   always_comb begin
      face_in   = face_ff;
      phase_in  = phase_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      second_in = second_ff;
      base_in   = base_ff;
      end_box   = 1'b0;
      col_inc   = {1'b0, col_ff} + (bmg_pkg::SEG_W + 1)'(1);
      row_inc   = {1'b0, row_ff} + (bmg_pkg::SEG_W + 1)'(1);
      if (cmd.accept && req_restart) begin
         face_in   = bmg_pkg::FACE_POS_X;
         phase_in  = 1'b0;
         col_in    = '0;
         row_in    = '0;
         second_in = 1'b0;
         base_in   = '0;
      end else if (cmd.finish) begin
         if (!phase_ff) begin
            col_in = col_inc[bmg_pkg::SEG_W-1:0];
            if (col_inc >= {1'b0, pitch}) begin
               col_in = '0;
               row_in = row_inc[bmg_pkg::SEG_W-1:0];
               if (row_inc >= {1'b0, rows}) begin
                  row_in    = '0;
                  phase_in  = 1'b1;
                  second_in = 1'b0;
               end
            end
         end else if (!second_ff) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            col_in    = col_inc[bmg_pkg::SEG_W-1:0];
            if (col_inc >= {1'b0, gx}) begin
               col_in = '0;
               row_in = row_inc[bmg_pkg::SEG_W-1:0];
               if (row_inc >= {1'b0, gy}) begin
                  row_in   = '0;
                  phase_in = 1'b0;
                  base_in  = base_ff + bmg_pkg::INDEX_W'(face_verts);
                  if (face_ff >= bmg_pkg::FACE_LAST) begin
                     face_in = bmg_pkg::FACE_POS_X;
                     base_in = '0;
                     end_box = 1'b1;
                  end else begin
                     face_in = face_ff + bmg_pkg::FACE_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_ff   <= bmg_pkg::FACE_POS_X;
         phase_ff  <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         second_ff <= 1'b0;
         base_ff   <= '0;
      end else begin
         face_ff   <= face_in;
         phase_ff  <= phase_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         second_ff <= second_in;
         base_ff   <= base_in;
      end
   end

   // result register, loaded from the current counters
   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 1'b0;
         last_ff <= 1'b0;
      end else if (cmd.finish) begin
         kind_ff <= phase_ff;
         last_ff <= phase_ff && end_box;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         face_id_ff <= face_ff;
         if (!phase_ff) begin
            pos_x_ff     <= place(bmg_pkg::AXIS_X, face_info, coord_u_ff, coord_v_ff, coord_w);
            pos_y_ff     <= place(bmg_pkg::AXIS_Y, face_info, coord_u_ff, coord_v_ff, coord_w);
            pos_z_ff     <= place(bmg_pkg::AXIS_Z, face_info, coord_u_ff, coord_v_ff, coord_w);
            tex_u_out_ff <= tex_u_ff;
            tex_v_out_ff <= bmg_pkg::TEX_ONE - tex_vf_ff;
            index_a_ff   <= '0;
            index_b_ff   <= '0;
            index_c_ff   <= '0;
         end else begin
            pos_x_ff     <= '0;
            pos_y_ff     <= '0;
            pos_z_ff     <= '0;
            tex_u_out_ff <= '0;
            tex_v_out_ff <= '0;
            index_a_ff   <= second_ff ? idx_b : idx_a;
            index_b_ff   <= second_ff ? idx_c : idx_b;
            index_c_ff   <= idx_d;
         end
      end
   end

   assign status.tri_phase = phase_ff;
   assign status.div_done  = div_done;

   assign rsp_record_kind = kind_ff;
   assign rsp_face_id     = face_id_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_tex_u       = tex_u_out_ff;
   assign rsp_tex_v       = tex_v_out_ff;
   assign rsp_index_a     = index_a_ff;
   assign rsp_index_b     = index_b_ff;
   assign rsp_index_c     = index_c_ff;
   assign rsp_last_record = last_ff;

`ifndef SYNTHESIS
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      face_ff <= bmg_pkg::FACE_LAST)
      else $error("face counter out of range");

   a_last_on_final_triangle: assert property (@(posedge clock) disable iff (reset)
      rsp_last_record |-> (rsp_record_kind && rsp_face_id == bmg_pkg::FACE_LAST))
      else $error("last record flag outside the final triangle of the box");
`endif

endmodule

/* hdl/bmg_controller.sv */
// ----------------------------------------------------------------------------
// bmg_controller
// Sequences one transaction: operand setup, four divisions for a vertex record, result hand-off.
// ----------------------------------------------------------------------------
module bmg_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bmg_pkg::cmd_type     cmd,
   input  bmg_pkg::status_type  status
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SETUP     = 6'b000010,
      ST_DIV_START = 6'b000100,
      ST_DIV_WAIT  = 6'b001000,
      ST_FINISH    = 6'b010000,
      ST_RESULT    = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   bmg_pkg::div_op_type  op_ff, op_in;

   function automatic bmg_pkg::div_op_type next_op(input bmg_pkg::div_op_type op);
      bmg_pkg::div_op_type r;
      case (op)
         bmg_pkg::DIV_POS_U: r = bmg_pkg::DIV_POS_V;
         bmg_pkg::DIV_POS_V: r = bmg_pkg::DIV_TEX_U;
         default:            r = bmg_pkg::DIV_TEX_V;
      endcase
      return r;
   endfunction

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.div_op = op_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.tri_phase) begin
               state_in = ST_FINISH;
            end else begin
               op_in    = bmg_pkg::DIV_POS_U;
               state_in = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.div_capture = 1'b1;
               if (op_ff == bmg_pkg::DIV_TEX_V) begin
                  state_in = ST_FINISH;
               end else begin
                  op_in    = next_op(op_ff);
                  state_in = ST_DIV_START;
               end
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            // hold the result until the consumer takes it
            if (!rsp_stall)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= bmg_pkg::DIV_POS_U;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESULT);

`ifndef SYNTHESIS
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> $past(cmd.div_start, bmg_pkg::DIV_CYCLES + 1))
      else $error("divider finished without a matching start");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider result arrived outside the wait state");

   a_finish_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished record not presented");

   a_delivery_frees_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !req_stall)
      else $error("input not reopened after delivery");
`endif

endmodule

/* hdl/box_mesh_generator_unit.sv */
// ----------------------------------------------------------------------------
// box_mesh_generator_unit
// Segmented box mesh generator: one vertex or triangle record per transaction.
// ----------------------------------------------------------------------------
// Each request transaction returns exactly one record. Faces run +x, -x, +y,
// -y, +z, -z; each face emits its grid vertices row by row, then two triangles
// per cell. A triangle record passes from one accepted request to the next
// through accept, setup, compute and present. A vertex record sends the two
// grid coordinates and the two UV values one after another through a single
// shared divider, which resolves four quotient bits per cycle; each division
// is a load, the iterative steps and a capture. A stalled result is held until
// the consumer takes it. Register writes take effect at once and are expected
// only between transactions.
// ----------------------------------------------------------------------------
module box_mesh_generator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_record_kind,
   output logic [bmg_pkg::FACE_W-1:0]            rsp_face_id,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_x,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_y,
   output logic signed [bmg_pkg::COORD_W-1:0]    rsp_pos_z,
   output logic [bmg_pkg::TEX_W-1:0]             rsp_tex_u,
   output logic [bmg_pkg::TEX_W-1:0]             rsp_tex_v,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_a,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_b,
   output logic [bmg_pkg::INDEX_W-1:0]           rsp_index_c,
   output logic                                  rsp_last_record,
   input  logic                                  csr_write,
   input  logic [bmg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [bmg_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   bmg_pkg::cmd_type     cmd;
   bmg_pkg::status_type  status;

   bmg_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bmg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_restart     (req_restart),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_record_kind (rsp_record_kind),
      .rsp_face_id     (rsp_face_id),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_index_a     (rsp_index_a),
      .rsp_index_b     (rsp_index_b),
      .rsp_index_c     (rsp_index_c),
      .rsp_last_record (rsp_last_record)
   );

endmodule

/* tb/sv/box_mesh_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// box_mesh_generator_unit_tb
// Self-checking bench for the box mesh generator. A short table of directed
// transactions covers reset geometry, restart, full-scale and zero extents,
// zero and oversized segment counts and unused register indexes. Random phases
// follow, each with fresh register settings. Every record is checked field by
// field against its table entry or a cycle-free face walk model in this bench.
// ----------------------------------------------------------------------------
module box_mesh_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmg_pkg::*;

   localparam logic RECORD_VERTEX   = 1'b0;
   localparam logic RECORD_TRIANGLE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 3'd7;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int SETTLE_CYCLES   = 4;
   localparam int END_CYCLES      = 60;
   localparam int FIELD_COUNT     = 11;

   typedef struct packed {
      logic                      kind;
      logic [FACE_W-1:0]         face;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [TEX_W-1:0]          tex_u;
      logic [TEX_W-1:0]          tex_v;
      logic [INDEX_W-1:0]        index_a;
      logic [INDEX_W-1:0]        index_b;
      logic [INDEX_W-1:0]        index_c;
      logic                      last;
   } mesh_record_t;

   // plane of one face: axes spanning it, the normal axis and their signs
   typedef struct packed {
      axis_type u_axis;
      axis_type v_axis;
      axis_type w_axis;
      logic     u_neg;
      logic     v_neg;
      logic     w_neg;
   } face_plane_t;

   typedef enum logic [1:0] {
      ROW_ASK,
      ROW_ASK_TYPED,
      ROW_WRITE
   } row_op_t;

   typedef struct packed {
      row_op_t                 op;
      logic [CSR_INDEX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0]   reg_data;
      logic                    restart;
      mesh_record_t            want;
   } directed_row_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_restart = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic                       rsp_record_kind;
   logic [FACE_W-1:0]          rsp_face_id;
   logic signed [COORD_W-1:0]  rsp_pos_x;
   logic signed [COORD_W-1:0]  rsp_pos_y;
   logic signed [COORD_W-1:0]  rsp_pos_z;
   logic [TEX_W-1:0]           rsp_tex_u;
   logic [TEX_W-1:0]           rsp_tex_v;
   logic [INDEX_W-1:0]         rsp_index_a;
   logic [INDEX_W-1:0]         rsp_index_b;
   logic [INDEX_W-1:0]         rsp_index_c;
   logic                       rsp_last_record;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   box_mesh_generator_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_record_kind (rsp_record_kind),
      .rsp_face_id     (rsp_face_id),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_index_a     (rsp_index_a),
      .rsp_index_b     (rsp_index_b),
      .rsp_index_c     (rsp_index_c),
      .rsp_last_record (rsp_last_record),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // register copies, indexed by axis
   logic [DIM_W-1:0] extent_reg [0:2] = '{16'd256, 16'd256, 16'd256};
   logic [SEG_W-1:0] segment_reg [0:2] = '{7'd1, 7'd1, 7'd1};

   // face walk state
   logic [FACE_W-1:0]  face_ctr = FACE_POS_X;
   logic               tri_phase = RECORD_VERTEX;
   int unsigned        col_ctr = 0;
   int unsigned        row_ctr = 0;
   logic               second_tri = 1'b0;
   logic [INDEX_W-1:0] vertex_base = '0;

   mesh_record_t pending_records [$];
   int           error_count = 0;
   int           records_seen = 0;
   int           sender_idle_pct = 32;
   int           receiver_idle_pct = 46;

   string field_names [FIELD_COUNT] = '{"record_kind", "face_id", "pos_x", "pos_y",
      "pos_z", "tex_u", "tex_v", "index_a", "index_b", "index_c", "last_record"};

   function automatic face_plane_t face_plane(input logic [FACE_W-1:0] face);
      case (face)
         FACE_NEG_X: return '{AXIS_Z, AXIS_Y, AXIS_X, 1'b0, 1'b1, 1'b1};
         FACE_POS_Y: return '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b0, 1'b0};
         FACE_NEG_Y: return '{AXIS_X, AXIS_Z, AXIS_Y, 1'b0, 1'b1, 1'b1};
         FACE_POS_Z: return '{AXIS_X, AXIS_Y, AXIS_Z, 1'b0, 1'b1, 1'b0};
         FACE_NEG_Z: return '{AXIS_X, AXIS_Y, AXIS_Z, 1'b1, 1'b1, 1'b1};
         default:    return '{AXIS_Z, AXIS_Y, AXIS_X, 1'b1, 1'b1, 1'b0};
      endcase
   endfunction

   function automatic longint cell_count(input logic [SEG_W-1:0] seg);
      if (seg == '0)
         return 1;
      if (seg > MAX_SEGMENTS)
         return MAX_SEGMENTS;
      return seg;
   endfunction

   // nearest, ties away from zero
   function automatic longint round_away(input longint num, input longint den);
      longint q;
      q = ((num < 0 ? -num : num) * 2 + den) / (2 * den);
      return num < 0 ? -q : q;
   endfunction

   function automatic longint grid_coord(input longint idx, input longint ext,
                                         input longint g, input logic neg);
      longint r;
      r = round_away(2 * idx * ext - g * ext, 2 * g);
      return neg ? -r : r;
   endfunction

   function automatic logic [COORD_W-1:0] clamp_coord(input longint x);
      if (x > 32767)
         return 16'h7FFF;
      if (x < -32768)
         return 16'h8000;
      return x[COORD_W-1:0];
   endfunction

   function automatic logic [TEX_W-1:0] grid_fraction(input longint idx, input longint g);
      longint q;
      q = (idx * 65536 + g / 2) / g;
      return (q > 65536) ? TEX_ONE : TEX_W'(q);
   endfunction

   task automatic next_mesh_record(input logic restart, output mesh_record_t rec);
      face_plane_t plane;
      longint      gu, gv, half;
      longint      pos [0:2];
      int unsigned pitch, a, b, c, d;
      logic        face_done;
      if (restart) begin
         face_ctr = FACE_POS_X;
         tri_phase = RECORD_VERTEX;
         col_ctr = 0;
         row_ctr = 0;
         second_tri = 1'b0;
         vertex_base = '0;
      end
      plane = face_plane(face_ctr);
      gu = cell_count(segment_reg[plane.u_axis]);
      gv = cell_count(segment_reg[plane.v_axis]);
      pitch = gu + 1;
      face_done = 1'b0;
      rec = '0;
      rec.kind = tri_phase;
      rec.face = face_ctr;
      if (tri_phase == RECORD_VERTEX) begin
         half = round_away(extent_reg[plane.w_axis], 2);
         pos[plane.u_axis] = grid_coord(col_ctr, extent_reg[plane.u_axis], gu, plane.u_neg);
         pos[plane.v_axis] = grid_coord(row_ctr, extent_reg[plane.v_axis], gv, plane.v_neg);
         pos[plane.w_axis] = plane.w_neg ? -half : half;
         rec.pos_x = clamp_coord(pos[0]);
         rec.pos_y = clamp_coord(pos[1]);
         rec.pos_z = clamp_coord(pos[2]);
         rec.tex_u = grid_fraction(col_ctr, gu);
         rec.tex_v = TEX_ONE - grid_fraction(row_ctr, gv);
         col_ctr++;
         if (col_ctr >= pitch) begin
            col_ctr = 0;
            row_ctr++;
            if (row_ctr >= gv + 1) begin
               row_ctr = 0;
               tri_phase = RECORD_TRIANGLE;
               second_tri = 1'b0;
            end
         end
      end else begin
         a = vertex_base + col_ctr + pitch * row_ctr;
         b = vertex_base + col_ctr + pitch * (row_ctr + 1);
         c = vertex_base + col_ctr + 1 + pitch * (row_ctr + 1);
         d = vertex_base + col_ctr + 1 + pitch * row_ctr;
         rec.index_c = d[INDEX_W-1:0];
         if (!second_tri) begin
            rec.index_a = a[INDEX_W-1:0];
            rec.index_b = b[INDEX_W-1:0];
            second_tri = 1'b1;
         end else begin
            rec.index_a = b[INDEX_W-1:0];
            rec.index_b = c[INDEX_W-1:0];
            second_tri = 1'b0;
            col_ctr++;
            if (col_ctr >= gu) begin
               col_ctr = 0;
               row_ctr++;
               face_done = (row_ctr >= gv);
            end
         end
         if (face_done) begin
            row_ctr = 0;
            tri_phase = RECORD_VERTEX;
            vertex_base = INDEX_W'(vertex_base + pitch * (gv + 1));
            if (face_ctr == FACE_LAST) begin
               rec.last = 1'b1;
               face_ctr = FACE_POS_X;
               vertex_base = '0;
            end else begin
               face_ctr = face_ctr + 1'b1;
            end
         end
      end
   endtask

   function automatic logic signed [63:0] record_field(input mesh_record_t r, input int k);
      case (k)
         0:       return r.kind;
         1:       return r.face;
         2:       return $signed(r.pos_x);
         3:       return $signed(r.pos_y);
         4:       return $signed(r.pos_z);
         5:       return r.tex_u;
         6:       return r.tex_v;
         7:       return r.index_a;
         8:       return r.index_b;
         9:       return r.index_c;
         default: return r.last;
      endcase
   endfunction

   function automatic mesh_record_t vertex_rec(input logic [FACE_W-1:0] face, input int x,
                                              input int y, input int z, input int u, input int v);
      mesh_record_t r;
      r = '0;
      r.kind = RECORD_VERTEX;
      r.face = face;
      r.pos_x = COORD_W'(x);
      r.pos_y = COORD_W'(y);
      r.pos_z = COORD_W'(z);
      r.tex_u = TEX_W'(u);
      r.tex_v = TEX_W'(v);
      return r;
   endfunction

   function automatic mesh_record_t triangle_rec(input logic [FACE_W-1:0] face, input int a,
                                                input int b, input int c);
      mesh_record_t r;
      r = '0;
      r.kind = RECORD_TRIANGLE;
      r.face = face;
      r.index_a = INDEX_W'(a);
      r.index_b = INDEX_W'(b);
      r.index_c = INDEX_W'(c);
      return r;
   endfunction

   function automatic directed_row_t ask(input logic restart);
      return '{ROW_ASK, '0, '0, restart, '0};
   endfunction

   function automatic directed_row_t ask_for(input logic restart, input mesh_record_t want);
      return '{ROW_ASK_TYPED, '0, '0, restart, want};
   endfunction

   function automatic directed_row_t set_reg(input logic [CSR_INDEX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] data);
      return '{ROW_WRITE, idx, data, 1'b0, '0};
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // leaves csr_write high; the caller drops it after the last write
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx <= CSR_BOX_DEPTH)
         extent_reg[idx] = data;
      else if (idx <= CSR_SEGMENTS_Z)
         segment_reg[idx - CSR_SEGMENTS_X] = data[SEG_W-1:0];
      @(posedge clock);
   endtask

   // valid stays high into the next transaction unless an idle cycle is drawn
   task automatic send_request(input logic restart, input logic typed,
                               input mesh_record_t want);
      mesh_record_t rec;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      next_mesh_record(restart, rec);
      pending_records.push_back(typed ? want : rec);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_random_settings();
      logic [CSR_DATA_W-1:0] value;
      for (int r = CSR_BOX_WIDTH; r <= CSR_SEGMENTS_Z; r++) begin
         if (r <= CSR_BOX_DEPTH) begin
            case ($urandom_range(4))
               0:       value = '0;
               1:       value = '1;
               2:       value = 16'd256;
               default: value = $urandom_range(16'hFFFF);
            endcase
         end else begin
            // upper data bits are random and must be dropped
            value = $urandom_range(16'hFFFF);
            case ($urandom_range(9))
               0:       value[SEG_W-1:0] = '0;
               1:       value[SEG_W-1:0] = SEG_W'(MAX_SEGMENTS);
               2:       value[SEG_W-1:0] = $urandom_range(127, MAX_SEGMENTS + 1);
               default: value[SEG_W-1:0] = $urandom_range(3, 1);
            endcase
         end
         write_register(CSR_INDEX_W'(r), value);
      end
      if ($urandom_range(1))
         write_register($urandom_range(1) ? CSR_UNUSED_HI : CSR_UNUSED_LO,
                        $urandom_range(16'hFFFF));
   endtask

   always @(posedge clock) begin : record_check
      mesh_record_t got, want;
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = '{rsp_record_kind, rsp_face_id, rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u,
                 rsp_tex_v, rsp_index_a, rsp_index_b, rsp_index_c, rsp_last_record};
         if (pending_records.size() == 0) begin
            report_error($sformatf("record %0d arrived with nothing pending", records_seen));
         end else begin
            want = pending_records.pop_front();
            for (int k = 0; k < FIELD_COUNT; k++)
               if (record_field(got, k) !== record_field(want, k))
                  report_error($sformatf("record %0d %s: got %0d, want %0d", records_seen,
                               field_names[k], record_field(got, k), record_field(want, k)));
         end
         records_seen++;
      end
   end

   initial begin
      #4_000_000;
      $display("box_mesh_generator_unit_tb failed");
      $finish;
   end

   initial begin
      directed_row_t rows [$];
      logic          prev_write;

      // unit cube, one cell per face, straight out of reset
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_POS_X, 128, 128, 128, 0, TEX_ONE)));
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_POS_X, 128, 128, -128, TEX_ONE, TEX_ONE)));
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_POS_X, 128, -128, 128, 0, 0)));
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_POS_X, 128, -128, -128, TEX_ONE, 0)));
      rows.push_back(ask_for(1'b0, triangle_rec(FACE_POS_X, 0, 2, 1)));
      rows.push_back(ask_for(1'b0, triangle_rec(FACE_POS_X, 2, 3, 1)));
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_NEG_X, -128, 128, -128, 0, TEX_ONE)));
      rows.push_back(ask_for(1'b1, vertex_rec(FACE_POS_X, 128, 128, 128, 0, TEX_ONE)));
      // full-scale extents, zero and oversized counts, unused indexes
      rows.push_back(set_reg(CSR_BOX_WIDTH, 16'hFFFF));
      rows.push_back(set_reg(CSR_BOX_HEIGHT, 16'hFFFF));
      rows.push_back(set_reg(CSR_BOX_DEPTH, 16'hFFFF));
      rows.push_back(set_reg(CSR_SEGMENTS_X, 16'h0000));
      rows.push_back(set_reg(CSR_SEGMENTS_Y, 16'h007F));
      rows.push_back(set_reg(CSR_SEGMENTS_Z, 16'hFFC0));
      rows.push_back(set_reg(CSR_UNUSED_LO, 16'h1234));
      rows.push_back(set_reg(CSR_UNUSED_HI, 16'hFFFF));
      rows.push_back(ask_for(1'b1, vertex_rec(FACE_POS_X, 32767, 32767, 32767, 0, TEX_ONE)));
      rows.push_back(ask(1'b0));
      rows.push_back(ask(1'b0));
      rows.push_back(ask(1'b0));
      // zero extents, and shrink the u grid under the running column
      rows.push_back(set_reg(CSR_BOX_WIDTH, 16'h0000));
      rows.push_back(set_reg(CSR_BOX_HEIGHT, 16'h0000));
      rows.push_back(set_reg(CSR_BOX_DEPTH, 16'h0000));
      rows.push_back(set_reg(CSR_SEGMENTS_Z, 16'h0002));
      rows.push_back(ask(1'b0));
      rows.push_back(ask(1'b0));
      rows.push_back(ask(1'b0));
      rows.push_back(ask(1'b0));
      // one cell per face at full scale: the -x plane sits at the low end of the range
      rows.push_back(set_reg(CSR_BOX_WIDTH, 16'hFFFF));
      rows.push_back(set_reg(CSR_BOX_HEIGHT, 16'hFFFF));
      rows.push_back(set_reg(CSR_BOX_DEPTH, 16'hFFFF));
      rows.push_back(set_reg(CSR_SEGMENTS_X, 16'h0000));
      rows.push_back(set_reg(CSR_SEGMENTS_Y, 16'h0000));
      rows.push_back(set_reg(CSR_SEGMENTS_Z, 16'h0000));
      rows.push_back(ask(1'b1));
      repeat (5) rows.push_back(ask(1'b0));
      rows.push_back(ask_for(1'b0, vertex_rec(FACE_NEG_X, -32768, 32767, -32768, 0, TEX_ONE)));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      prev_write = 1'b0;
      foreach (rows[r]) begin
         if (rows[r].op == ROW_WRITE) begin
            if (!prev_write) begin
               req_valid <= 1'b0;
               drain_results();
            end
            write_register(rows[r].reg_index, rows[r].reg_data);
            prev_write = 1'b1;
         end else begin
            if (prev_write)
               csr_write <= 1'b0;
            send_request(rows[r].restart, rows[r].op == ROW_ASK_TYPED, rows[r].want);
            prev_write = 1'b0;
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         req_valid <= 1'b0;
         drain_results();
         if (phase < RANDOM_PHASES * 3 / 10) begin
            sender_idle_pct = 32;
            receiver_idle_pct = 46;
         end else if (phase < RANDOM_PHASES * 6 / 10) begin
            sender_idle_pct = 46;
            receiver_idle_pct = 32;
         end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         apply_random_settings();
         csr_write <= 1'b0;
         // half the phases carry on mid-box under the new settings
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(n == 0 ? 1'($urandom_range(1)) : ($urandom_range(99) < 2),
                         1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("box_mesh_generator_unit_tb passed");
      else
         $display("box_mesh_generator_unit_tb failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/bmg_pkg.sv
hdl/bmg_divider.sv
hdl/bmg_datapath.sv
hdl/bmg_controller.sv
hdl/box_mesh_generator_unit.sv
tb/sv/box_mesh_generator_unit_tb.sv
